// File: rtl/sct_pkg.sv
// shared types and constants for the shell command tokenizer
// no dependencies; every other file but sct_if imports this package

package sct_pkg;

    localparam int MaxEvents = 4;
    localparam int CountW    = 3;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_LESS    = 8'h3C;
    localparam logic [7:0] CH_GREATER = 8'h3E;
    localparam logic [7:0] CH_PIPE    = 8'h7C;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;

    localparam logic [1:0] EV_CHAR = 2'd0;
    localparam logic [1:0] EV_END  = 2'd1;
    localparam logic [1:0] EV_EOL  = 2'd2;

    typedef struct packed {
        logic [7:0] sym;
        logic [1:0] kind;
        logic       err;
        logic       last;
    } event_t;

    // decoded event list handed from the decoder to the result buffer
    typedef struct packed {
        logic                        valid;
        logic [CountW-1:0]           count;
        event_t [MaxEvents-1:0]      ev;
    } dec_out_t;

    function automatic event_t mk_event(logic [7:0] sym, logic [1:0] kind, logic err);
        event_t e;
        e.sym  = sym;
        e.kind = kind;
        e.err  = err;
        e.last = 1'b0;
        return e;
    endfunction

endpackage

// File: rtl/sct_if.sv
// handshake channels of the tokenizer: byte input and event output
// no dependencies

interface sct_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       line_end;

    modport source (output valid, output symbol, output line_end, input ready);
    modport sink   (input valid, input symbol, input line_end, output ready);
endinterface

interface sct_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_symbol;
    logic [1:0] event_kind;
    logic       open_quote_error;
    logic       last_of_run;

    modport source (output valid, output out_symbol, output event_kind,
                     output open_quote_error, output last_of_run, input ready);
    modport sink   (input valid, input out_symbol, input event_kind,
                    input open_quote_error, input last_of_run, output ready);
endinterface

// File: rtl/shell_command_tokenizer_top.sv
// Shell command tokenizer: takes one command-line byte per transfer on bytes and
// produces token-character, end-of-token and end-of-line events on events. A byte
// is registered, decoded combinationally into up to four events, and these sit
// in a result buffer that sends one per transfer. Throughput is one byte per cycle
// while each byte yields at most one event and events are taken; a byte yielding
// several events holds the buffer until its last is taken, one yielding none still
// passes through it. A byte's events leave via the input and buffer registers.
// depends on sct_pkg, sct_if, sct_decode and sct_evbuf

module shell_command_tokenizer_top (
    input  logic      clk,
    input  logic      rst_n,
    sct_in_if.sink    bytes,
    sct_out_if.source events
);
    import sct_pkg::*;

    dec_out_t dec;
    logic     free;

    sct_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .bytes (bytes),
        .take  (free),
        .dec   (dec)
    );

    sct_evbuf u_evbuf (
        .clk    (clk),
        .rst_n  (rst_n),
        .dec    (dec),
        .free   (free),
        .events (events)
    );

endmodule

// File: rtl/sct_decode.sv
// input register, lexer state and the per-byte event decode
// depends on sct_pkg and sct_in_if

module sct_decode (
    input  logic             clk,
    input  logic             rst_n,
    sct_in_if.sink           bytes,
    input  logic             take,
    output sct_pkg::dec_out_t dec
);
    import sct_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] sym_reg;
    logic       end_reg;
    logic       quote_reg, quote_next;
    logic       open_reg, open_next;
    logic       gt_reg, gt_next;

    logic                   consume;
    logic [CountW-1:0]      n;
    event_t [MaxEvents-1:0] evs;
    logic                   handled;
    logic                   special;

    assign consume     = in_valid_reg && take;
    assign bytes.ready = !in_valid_reg || take;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (bytes.ready)
        begin
            in_valid_next = bytes.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            quote_reg    <= 1'b0;
            open_reg     <= 1'b0;
            gt_reg       <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (consume)
            begin
                quote_reg <= quote_next;
                open_reg  <= open_next;
                gt_reg    <= gt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes.valid && bytes.ready)
        begin
            sym_reg <= bytes.symbol;
            end_reg <= bytes.line_end;
        end
    end

    assign special = (sym_reg == CH_LESS) || (sym_reg == CH_PIPE) ||
                     (sym_reg == CH_SEMI) || (sym_reg == CH_AMP) ||
                     (sym_reg == CH_DOLLAR);

    always_comb
    begin
        n          = '0;
        evs        = '0;
        handled    = 1'b0;
        quote_next = quote_reg;
        open_next  = open_reg;
        gt_next    = gt_reg;

        // a pending > either pairs into >> or is ended first
        if (gt_reg)
        begin
            gt_next = 1'b0;
            if (sym_reg == CH_GREATER)
            begin
                evs[n[1:0]] = mk_event(sym_reg, EV_CHAR, 1'b0);
                n = n + 1'b1;
                evs[n[1:0]] = mk_event(8'h00, EV_END, 1'b0);
                n = n + 1'b1;
                handled = 1'b1;
            end
            else
            begin
                evs[n[1:0]] = mk_event(8'h00, EV_END, 1'b0);
                n = n + 1'b1;
            end
        end

        if (!handled)
        begin
            if (quote_next)
            begin
                if (sym_reg == CH_QUOTE)
                begin
                    quote_next = 1'b0;
                end
                else
                begin
                    evs[n[1:0]] = mk_event(sym_reg, EV_CHAR, 1'b0);
                    n = n + 1'b1;
                    open_next = 1'b1;
                end
            end
            else if (sym_reg == CH_SPACE || sym_reg == CH_QUOTE ||
                     sym_reg == CH_GREATER || special)
            begin
                if (open_next)
                begin
                    evs[n[1:0]] = mk_event(8'h00, EV_END, 1'b0);
                    n = n + 1'b1;
                    open_next = 1'b0;
                end
                if (sym_reg == CH_QUOTE)
                begin
                    quote_next = 1'b1;
                end
                else if (sym_reg == CH_GREATER)
                begin
                    evs[n[1:0]] = mk_event(sym_reg, EV_CHAR, 1'b0);
                    n = n + 1'b1;
                    gt_next = 1'b1;
                end
                else if (special)
                begin
                    evs[n[1:0]] = mk_event(sym_reg, EV_CHAR, 1'b0);
                    n = n + 1'b1;
                    evs[n[1:0]] = mk_event(8'h00, EV_END, 1'b0);
                    n = n + 1'b1;
                end
            end
            else
            begin
                evs[n[1:0]] = mk_event(sym_reg, EV_CHAR, 1'b0);
                n = n + 1'b1;
                open_next = 1'b1;
            end
        end

        // end of line closes whatever is open, then marks the line
        if (end_reg)
        begin
            if (gt_next || open_next)
            begin
                evs[n[1:0]] = mk_event(8'h00, EV_END, 1'b0);
                n = n + 1'b1;
            end
            evs[n[1:0]] = mk_event(8'h00, EV_EOL, quote_next);
            n = n + 1'b1;
            quote_next = 1'b0;
            open_next  = 1'b0;
            gt_next    = 1'b0;
        end

        for (int i = 0; i < MaxEvents; i++)
        begin
            evs[i].last = (CountW'(i) == n - 1'b1);
        end
    end

    assign dec.valid = in_valid_reg;
    assign dec.count = n;
    assign dec.ev    = evs;

endmodule

// File: rtl/sct_evbuf.sv
// result buffer: holds the events of one byte and hands them out one per transfer
// depends on sct_pkg and sct_out_if

module sct_evbuf (
    input  logic              clk,
    input  logic              rst_n,
    input  sct_pkg::dec_out_t dec,
    output logic              free,
    sct_out_if.source         events
);
    import sct_pkg::*;

    event_t [MaxEvents-1:0] ev_reg;
    logic [CountW-1:0]      cnt_reg, cnt_next;
    logic                   load;
    logic                   pop;

    // free once the buffer is empty or its final event leaves this cycle
    assign free = (cnt_reg == '0) || ((cnt_reg == CountW'(1)) && events.ready);
    assign load = dec.valid && free;
    assign pop  = events.valid && events.ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (load)
        begin
            cnt_next = dec.count;
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ev_reg <= dec.ev;
        end
        else if (pop)
        begin
            for (int i = 0; i < MaxEvents - 1; i++)
            begin
                ev_reg[i] <= ev_reg[i+1];
            end
        end
    end

    assign events.valid            = (cnt_reg != '0);
    assign events.out_symbol       = ev_reg[0].sym;
    assign events.event_kind       = ev_reg[0].kind;
    assign events.open_quote_error = ev_reg[0].err;
    assign events.last_of_run      = ev_reg[0].last;

endmodule

// File: rtl/sct_checker.sv
// port-level checks on the tokenizer event stream, bound to the top level
// depends on sct_pkg and shell_command_tokenizer_top

module sct_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       ev_valid,
    input logic       ev_ready,
    input logic [7:0] ev_symbol,
    input logic [1:0] ev_kind,
    input logic       ev_err,
    input logic       ev_last
);
    import sct_pkg::*;

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid |-> (ev_kind == EV_CHAR || ev_kind == EV_END || ev_kind == EV_EOL))
        else $error("illegal event kind");

    a_symbol_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ev_valid && ev_kind != EV_CHAR) |-> (ev_symbol == 8'h00))
        else $error("nonzero symbol on a non-character event");

    a_err_only_eol: assert property (@(posedge clk) disable iff (!rst_n)
        (ev_valid && ev_err) |-> (ev_kind == EV_EOL))
        else $error("quote error outside an end-of-line event");

    a_eol_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ev_valid && ev_kind == EV_EOL) |-> ev_last)
        else $error("end-of-line event is not last of its run");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ev_valid && !ev_ready) |=> (ev_valid && $stable(ev_symbol) &&
            $stable(ev_kind) && $stable(ev_err) && $stable(ev_last)))
        else $error("stalled event changed");

endmodule

bind shell_command_tokenizer_top sct_checker u_sct_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev_valid  (events.valid),
    .ev_ready  (events.ready),
    .ev_symbol (events.out_symbol),
    .ev_kind   (events.event_kind),
    .ev_err    (events.open_quote_error),
    .ev_last   (events.last_of_run)
);
